### rtl/core/pairwise_color_force_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Pairwise color force accumulator assertion macros
// Shared concurrent assertion forms used by the block's top level.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_COLOR_FORCE_ACCUMULATOR_DEFINES_SVH
`define PAIRWISE_COLOR_FORCE_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCFA_ASSERT_NOW(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCFA_ASSERT_NEXT(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pcfa_pkg.sv
// ----------------------------------------------------------------------------
// Pairwise color force accumulator package
// Types, constants and helper functions shared by the block's modules.
// ----------------------------------------------------------------------------
package pcfa_pkg;

    localparam int COLORS     = 8;
    localparam int COLOR_W    = 3;
    localparam int TAB_DEPTH  = COLORS * COLORS;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 6;
    localparam int SQRT_STEPS = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMESTEP  = 2'd3;

    localparam logic [30:0] RST_BOX_HALF = 31'd6553600;
    localparam logic [30:0] RST_RADIUS   = 31'd655360;
    localparam logic [15:0] RST_RATIO    = 16'd19661;
    localparam logic [30:0] RST_TIMESTEP = 31'd1092;

    // Item classes decided by the front end.
    localparam logic [1:0] CL_WRITE = 2'd0;
    localparam logic [1:0] CL_SKIP  = 2'd1;
    localparam logic [1:0] CL_PAIR  = 2'd2;

    typedef struct packed {
        logic                    kind;
        logic signed [31:0]      self_x;
        logic signed [31:0]      self_y;
        logic [COLOR_W-1:0]      self_color;
        logic signed [31:0]      other_x;
        logic signed [31:0]      other_y;
        logic [COLOR_W-1:0]      other_color;
        logic                    same_particle;
        logic                    last;
        logic signed [15:0]      matrix_value;
    } t_in;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
    } t_out;

    typedef struct packed {
        logic [30:0] box_half_size;
        logic [30:0] interaction_radius;
        logic [15:0] repulsion_ratio;
        logic [30:0] timestep;
    } t_cfg;

    typedef struct packed {
        logic [1:0]          cls;
        logic signed [32:0]  dx;
        logic signed [32:0]  dy;
        logic [COLOR_W-1:0]  self_color;
        logic [COLOR_W-1:0]  other_color;
        logic                last;
        logic signed [15:0]  matrix_value;
    } t_entry;

    typedef struct packed {
        logic pop;
        logic out_load;
    } t_bk_stat;

    function automatic logic color_ok(input logic [COLOR_W-1:0] c);
        return 32'(c) < COLORS;
    endfunction

    function automatic logic [TAB_AW-1:0] tab_addr(input logic [COLOR_W-1:0] row,
                                                   input logic [COLOR_W-1:0] col);
        return TAB_AW'(row) * TAB_AW'(COLORS) + TAB_AW'(col);
    endfunction

    // Saturating add of a signed term into a 48 bit sum.
    function automatic logic signed [47:0] sat_add48(input logic signed [47:0] s,
                                                    input logic signed [52:0] t);
        logic signed [53:0] w;
        w = 54'(s) + 54'(t);
        if (w > 54'sh7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (w < -54'sh8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end else begin
            return w[47:0];
        end
    endfunction

endpackage

### rtl/core/pcfa_front.sv
// ----------------------------------------------------------------------------
// Pairwise color force accumulator front end
// Accepts input beats, classifies them and forms the raw position offsets.
// ----------------------------------------------------------------------------
module pcfa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pcfa_pkg::t_in     i_in_data,
    input  logic              i_fifo_full,
    output logic              o_push,
    output pcfa_pkg::t_entry  o_ent
);

    logic              r_valid;
    logic              n_valid;
    pcfa_pkg::t_entry  r_ent;
    pcfa_pkg::t_entry  w_ent;
    logic              w_accept;

    always_comb begin
        w_ent.dx           = 33'(i_in_data.other_x) - 33'(i_in_data.self_x);
        w_ent.dy           = 33'(i_in_data.other_y) - 33'(i_in_data.self_y);
        w_ent.self_color   = i_in_data.self_color;
        w_ent.other_color  = i_in_data.other_color;
        w_ent.last         = i_in_data.last;
        w_ent.matrix_value = i_in_data.matrix_value;
        if (!i_in_data.kind) begin
            w_ent.cls = pcfa_pkg::CL_WRITE;
        end else if (i_in_data.same_particle) begin
            w_ent.cls = pcfa_pkg::CL_SKIP;
        end else begin
            w_ent.cls = pcfa_pkg::CL_PAIR;
        end
    end

    assign o_in_stall = r_valid && i_fifo_full;
    assign o_push     = r_valid && !i_fifo_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_ent      = r_ent;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ent <= w_ent;
        end
    end

endmodule

### rtl/core/pcfa_fifo.sv
// ----------------------------------------------------------------------------
// Pairwise color force accumulator queue
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module pcfa_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcfa_pkg::t_entry  i_data,
    input  logic              i_pop,
    output pcfa_pkg::t_entry  o_head,
    output logic              o_full,
    output logic              o_empty
);

    pcfa_pkg::t_entry                r_mem [pcfa_pkg::FIFO_DEPTH];
    logic [pcfa_pkg::FIFO_AW-1:0]    r_wp;
    logic [pcfa_pkg::FIFO_AW-1:0]    r_rp;
    logic [pcfa_pkg::FIFO_CW-1:0]    r_cnt;
    logic [pcfa_pkg::FIFO_CW-1:0]    n_cnt;

    assign o_full  = r_cnt == pcfa_pkg::FIFO_CW'(pcfa_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (32'(r_wp) == pcfa_pkg::FIFO_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == pcfa_pkg::FIFO_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/core/pcfa_div.sv
// ----------------------------------------------------------------------------
// Pairwise color force accumulator divider
// Restoring divider, one quotient bit a cycle, 32 bit quotient.
// ----------------------------------------------------------------------------
module pcfa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quo
);

    logic [31:0]                     r_rem;
    logic [31:0]                     r_dvd;
    logic [31:0]                     r_div;
    logic [pcfa_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [32:0]                     w_trial;
    logic [32:0]                     w_diff;
    logic                            w_ge;

    // The caller guarantees the quotient fits in 32 bits, so the upper half
    // of the dividend is already below the divisor.
    assign w_trial = {r_rem, r_dvd[31]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign o_busy  = r_cnt != '0;
    assign o_quo   = r_dvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= pcfa_pkg::DIV_CNT_W'(pcfa_pkg::DIV_STEPS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_dvd <= i_dividend[31:0];
            r_div <= i_divisor;
        end else if (o_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_dvd <= {r_dvd[30:0], w_ge};
        end
    end

endmodule

### rtl/core/pcfa_back.sv
// ----------------------------------------------------------------------------
// Pairwise color force accumulator back end
// Sequencer that evaluates one pair force, accumulates it and emits sums.
// ----------------------------------------------------------------------------
module pcfa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcfa_pkg::t_cfg     i_cfg,
    input  logic               i_fifo_empty,
    input  pcfa_pkg::t_entry   i_head,
    output pcfa_pkg::t_bk_stat o_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pcfa_pkg::t_out     o_out_data
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_WRAP1 = 5'd1;
    localparam logic [4:0] ST_WRAP2 = 5'd2;
    localparam logic [4:0] ST_RANGE = 5'd3;
    localparam logic [4:0] ST_SQ    = 5'd4;
    localparam logic [4:0] ST_SUM   = 5'd5;
    localparam logic [4:0] ST_SQRT  = 5'd6;
    localparam logic [4:0] ST_DCHK  = 5'd7;
    localparam logic [4:0] ST_DIV1  = 5'd8;
    localparam logic [4:0] ST_SEL   = 5'd9;
    localparam logic [4:0] ST_PROD  = 5'd10;
    localparam logic [4:0] ST_DIV2  = 5'd11;
    localparam logic [4:0] ST_TAB   = 5'd12;
    localparam logic [4:0] ST_TS    = 5'd13;
    localparam logic [4:0] ST_TERM  = 5'd14;
    localparam logic [4:0] ST_ACC   = 5'd15;
    localparam logic [4:0] ST_FIN   = 5'd16;

    logic [4:0]                          r_state;
    logic [4:0]                          n_state;

    logic signed [33:0]                  r_dx;
    logic signed [33:0]                  r_dy;
    logic [pcfa_pkg::COLOR_W-1:0]        r_sc;
    logic [pcfa_pkg::COLOR_W-1:0]        r_oc;
    logic                                r_last;
    logic [30:0]                         r_magx;
    logic [30:0]                         r_magy;
    logic                                r_sgnx;
    logic                                r_sgny;
    logic [61:0]                         r_sqx;
    logic [61:0]                         r_sqy;
    logic [63:0]                         r_rad;
    logic [31:0]                         r_root;
    logic [33:0]                         r_srem;
    logic [pcfa_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [30:0]                         r_rr;
    logic                                r_reg1;
    logic [31:0]                         r_smag;
    logic                                r_ssgn;
    logic [35:0]                         r_cmagx;
    logic [35:0]                         r_cmagy;
    logic                                r_csgx;
    logic                                r_csgy;
    logic [50:0]                         r_phx;
    logic [50:0]                         r_phy;
    logic [30:0]                         r_plx;
    logic [30:0]                         r_ply;
    logic signed [52:0]                  r_termx;
    logic signed [52:0]                  r_termy;
    logic signed [47:0]                  r_sumx;
    logic signed [47:0]                  r_sumy;
    logic                                r_out_valid;
    pcfa_pkg::t_out                      r_out;

    logic signed [15:0]                  r_tab [pcfa_pkg::TAB_DEPTH];
    logic signed [15:0]                  r_tab_q;

    logic signed [33:0]                  w_h;
    logic signed [33:0]                  w_h2;
    logic [33:0]                         w_absx;
    logic [33:0]                         w_absy;
    logic                                w_far;
    logic [46:0]                         w_rrp;
    logic [35:0]                         w_st;
    logic [35:0]                         w_tr;
    logic                                w_sge;
    logic                                w_dbad;
    logic                                w_reg1;
    logic signed [34:0]                  w_num;
    logic [33:0]                         w_anum;
    logic [63:0]                         w_dvd1;
    logic [31:0]                         w_dsr1;
    logic signed [32:0]                  w_sdiff;
    logic [62:0]                         w_px;
    logic [62:0]                         w_py;
    logic [15:0]                         w_mmag;
    logic                                w_msgn;
    logic [47:0]                         w_mx;
    logic [47:0]                         w_my;
    logic [46:0]                         w_lx;
    logic [46:0]                         w_ly;
    logic [51:0]                         w_tmx;
    logic [51:0]                         w_tmy;
    logic                                w_pop;
    logic                                w_out_load;
    logic                                w_tab_we;
    logic                                w_start1;
    logic                                w_start2;
    logic [63:0]                         w_dvdx;
    logic [63:0]                         w_dvdy;
    logic                                w_busy_x;
    logic                                w_busy_y;
    logic [31:0]                         w_quo_x;
    logic [31:0]                         w_quo_y;

    pcfa_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start1 || w_start2),
        .i_dividend (w_start1 ? w_dvd1 : w_dvdx),
        .i_divisor  (w_start1 ? w_dsr1 : r_root),
        .o_busy     (w_busy_x),
        .o_quo      (w_quo_x)
    );

    pcfa_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start2),
        .i_dividend (w_dvdy),
        .i_divisor  (r_root),
        .o_busy     (w_busy_y),
        .o_quo      (w_quo_y)
    );

    always_comb begin
        w_h     = 34'(i_cfg.box_half_size);
        w_h2    = 34'({i_cfg.box_half_size, 1'b0});
        w_absx  = r_dx[33] ? 34'(-r_dx) : 34'(r_dx);
        w_absy  = r_dy[33] ? 34'(-r_dy) : 34'(r_dy);
        w_far   = (w_absx > 34'(i_cfg.interaction_radius)) ||
                  (w_absy > 34'(i_cfg.interaction_radius));
        w_rrp   = 47'(i_cfg.repulsion_ratio) * 47'(i_cfg.interaction_radius);

        // One step of the digit-by-digit square root, two radicand bits a step.
        w_st    = {r_srem, r_rad[63:62]};
        w_tr    = {2'b00, r_root, 2'b01};
        w_sge   = w_st >= w_tr;

        w_dbad  = (r_root == '0) || (r_root > 32'(i_cfg.interaction_radius));
        w_reg1  = r_root <= 32'(r_rr);
        w_num   = 35'({r_root, 1'b0}) - 35'(i_cfg.interaction_radius) - 35'(r_rr);
        w_anum  = w_num[34] ? 34'(-w_num) : 34'(w_num);
        w_dvd1  = w_reg1 ? {16'b0, r_root, 16'b0} : {14'b0, w_anum, 16'b0};
        w_dsr1  = w_reg1 ? 32'(i_cfg.repulsion_ratio)
                         : 32'(17'h1_0000 - 17'(i_cfg.repulsion_ratio));

        w_sdiff = 33'(i_cfg.interaction_radius) - 33'(w_quo_x);
        w_px    = 63'(r_smag) * 63'(r_magx);
        w_py    = 63'(r_smag) * 63'(r_magy);
        w_dvdx  = {1'b0, w_px};
        w_dvdy  = {1'b0, w_py};

        // An out-of-range color reads as a zero attraction scale.
        if (pcfa_pkg::color_ok(r_sc) && pcfa_pkg::color_ok(r_oc)) begin
            w_mmag = r_tab_q[15] ? 16'(-r_tab_q) : 16'(r_tab_q);
            w_msgn = r_tab_q[15];
        end else begin
            w_mmag = '0;
            w_msgn = 1'b0;
        end
        w_mx    = 48'(w_quo_x) * 48'(w_mmag);
        w_my    = 48'(w_quo_y) * 48'(w_mmag);
        w_lx    = 47'(r_cmagx[15:0]) * 47'(i_cfg.timestep);
        w_ly    = 47'(r_cmagy[15:0]) * 47'(i_cfg.timestep);
        w_tmx   = 52'(r_phx) + 52'(r_plx);
        w_tmy   = 52'(r_phy) + 52'(r_ply);
    end

    assign w_pop      = (r_state == ST_IDLE) && !i_fifo_empty;
    assign w_tab_we   = w_pop && (i_head.cls == pcfa_pkg::CL_WRITE) &&
                        pcfa_pkg::color_ok(i_head.self_color) &&
                        pcfa_pkg::color_ok(i_head.other_color);
    assign w_start1   = (r_state == ST_DCHK) && !w_dbad;
    assign w_start2   = r_state == ST_PROD;
    assign w_out_load = (r_state == ST_FIN) && r_last && (!r_out_valid || !i_out_stall);

    assign o_stat.pop      = w_pop;
    assign o_stat.out_load = w_out_load;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    case (i_head.cls)
                        pcfa_pkg::CL_PAIR: n_state = ST_WRAP1;
                        pcfa_pkg::CL_SKIP: n_state = ST_FIN;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRAP1: n_state = ST_WRAP2;
            ST_WRAP2: n_state = ST_RANGE;
            ST_RANGE: n_state = w_far ? ST_FIN : ST_SQ;
            ST_SQ:    n_state = ST_SUM;
            ST_SUM:   n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == pcfa_pkg::DIV_CNT_W'(1)) begin
                    n_state = ST_DCHK;
                end
            end
            ST_DCHK:  n_state = w_dbad ? ST_FIN : ST_DIV1;
            ST_DIV1:  n_state = w_busy_x ? ST_DIV1 : ST_SEL;
            ST_SEL:   n_state = ST_PROD;
            ST_PROD:  n_state = ST_DIV2;
            ST_DIV2:  n_state = (w_busy_x || w_busy_y) ? ST_DIV2 : ST_TAB;
            ST_TAB:   n_state = ST_TS;
            ST_TS:    n_state = ST_TERM;
            ST_TERM:  n_state = ST_ACC;
            ST_ACC:   n_state = ST_FIN;
            ST_FIN: begin
                if (!r_last || w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sumx      <= '0;
            r_sumy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC) begin
                r_sumx <= pcfa_pkg::sat_add48(r_sumx, r_termx);
                r_sumy <= pcfa_pkg::sat_add48(r_sumy, r_termy);
            end else if (w_out_load) begin
                r_sumx <= '0;
                r_sumy <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.force_x <= r_sumx;
            r_out.force_y <= r_sumy;
        end
        case (r_state)
            ST_IDLE: begin
                r_dx   <= 34'(i_head.dx);
                r_dy   <= 34'(i_head.dy);
                r_sc   <= i_head.self_color;
                r_oc   <= i_head.other_color;
                r_last <= i_head.last;
            end
            ST_WRAP1: begin
                if (r_dx > w_h) begin
                    r_dx <= r_dx - w_h2;
                end
                if (r_dy > w_h) begin
                    r_dy <= r_dy - w_h2;
                end
            end
            ST_WRAP2: begin
                if (r_dx < -w_h) begin
                    r_dx <= r_dx + w_h2;
                end
                if (r_dy < -w_h) begin
                    r_dy <= r_dy + w_h2;
                end
            end
            ST_RANGE: begin
                r_magx <= w_absx[30:0];
                r_magy <= w_absy[30:0];
                r_sgnx <= r_dx[33];
                r_sgny <= r_dy[33];
            end
            ST_SQ: begin
                r_sqx <= 62'(r_magx) * 62'(r_magx);
                r_sqy <= 62'(r_magy) * 62'(r_magy);
                r_rr  <= w_rrp[46:16];
            end
            ST_SUM: begin
                r_rad  <= 64'(r_sqx) + 64'(r_sqy);
                r_root <= '0;
                r_srem <= '0;
                r_cnt  <= pcfa_pkg::DIV_CNT_W'(pcfa_pkg::SQRT_STEPS);
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
                r_srem <= w_sge ? 34'(w_st - w_tr) : w_st[33:0];
                r_root <= {r_root[30:0], w_sge};
            end
            ST_DCHK: begin
                r_reg1 <= w_reg1;
            end
            ST_SEL: begin
                r_smag <= w_sdiff[32] ? 32'(-w_sdiff) : w_sdiff[31:0];
                r_ssgn <= r_reg1 || w_sdiff[32];
            end
            ST_TAB: begin
                if (r_reg1) begin
                    r_cmagx <= 36'(w_quo_x);
                    r_cmagy <= 36'(w_quo_y);
                end else begin
                    r_cmagx <= w_mx[47:12];
                    r_cmagy <= w_my[47:12];
                end
                r_csgx <= r_ssgn ^ r_sgnx ^ (!r_reg1 && w_msgn);
                r_csgy <= r_ssgn ^ r_sgny ^ (!r_reg1 && w_msgn);
            end
            ST_TS: begin
                r_phx <= 51'(r_cmagx[35:16]) * 51'(i_cfg.timestep);
                r_phy <= 51'(r_cmagy[35:16]) * 51'(i_cfg.timestep);
                r_plx <= w_lx[46:16];
                r_ply <= w_ly[46:16];
            end
            ST_TERM: begin
                r_termx <= r_csgx ? -53'(w_tmx) : 53'(w_tmx);
                r_termy <= r_csgy ? -53'(w_tmy) : 53'(w_tmy);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_tab[pcfa_pkg::tab_addr(i_head.self_color, i_head.other_color)]
                <= i_head.matrix_value;
        end
        r_tab_q <= r_tab[pcfa_pkg::tab_addr(r_sc, r_oc)];
    end

endmodule

### rtl/core/pairwise_color_force_accumulator.sv
// ----------------------------------------------------------------------------
// Pairwise color force accumulator
// Accumulates color-dependent pair forces per particle and emits the sums.
// ----------------------------------------------------------------------------
// Input beats carry either an attraction table write (kind 0) or one particle
// pair (kind 1). Output beats carry the saturated x and y force sums and are
// produced only for a pair beat with last set; the sums then restart at zero.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. Configuration registers are written through a plain write
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. The back end evaluates a pair beat with
// the 32 step square root and two rounds of the 32 step divider. A table
// write and a pair marked as the same particle skip that evaluation. The
// front register and a two entry queue take new beats while the back end
// works. A result shows the cycle after the back end finishes the last pair.
// When the receiver stalls, the result waits in the output register and the
// back end holds at its next result until that register frees up.
// Reset clears the sums, queue and handshakes and loads the default
// configuration; the attraction table is undefined until written.
// ----------------------------------------------------------------------------
`include "pairwise_color_force_accumulator_defines.svh"

module pairwise_color_force_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pcfa_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pcfa_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [pcfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pcfa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pcfa_pkg::t_cfg      r_cfg;
    pcfa_pkg::t_entry    w_ent;
    pcfa_pkg::t_entry    w_head;
    pcfa_pkg::t_bk_stat  w_stat;
    logic                w_push;
    logic                w_fifo_full;
    logic                w_fifo_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_half_size      <= pcfa_pkg::RST_BOX_HALF;
            r_cfg.interaction_radius <= pcfa_pkg::RST_RADIUS;
            r_cfg.repulsion_ratio    <= pcfa_pkg::RST_RATIO;
            r_cfg.timestep           <= pcfa_pkg::RST_TIMESTEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcfa_pkg::CFG_BOX_HALF: r_cfg.box_half_size      <= i_cfg_data;
                pcfa_pkg::CFG_RADIUS:   r_cfg.interaction_radius <= i_cfg_data;
                pcfa_pkg::CFG_RATIO:    r_cfg.repulsion_ratio    <= i_cfg_data[15:0];
                pcfa_pkg::CFG_TIMESTEP: r_cfg.timestep           <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pcfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_fifo_full (w_fifo_full),
        .o_push      (w_push),
        .o_ent       (w_ent)
    );

    pcfa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_ent),
        .i_pop   (w_stat.pop),
        .o_head  (w_head),
        .o_full  (w_fifo_full),
        .o_empty (w_fifo_empty)
    );

    pcfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_fifo_empty (w_fifo_empty),
        .i_head       (w_head),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    `PCFA_ASSERT_NOW(a_pop_not_empty, i_rst_n, w_stat.pop, !w_fifo_empty, "pop from empty queue")
    `PCFA_ASSERT_NOW(a_push_not_full, i_rst_n, w_push, !w_fifo_full, "push into full queue")
    `PCFA_ASSERT_NOW(a_load_when_free, i_rst_n, w_stat.out_load, !o_out_valid || !i_out_stall, "result overwritten")
    `PCFA_ASSERT_NEXT(a_load_shows, i_rst_n, w_stat.out_load, o_out_valid, "loaded result not shown")

endmodule

### bench/pairwise_color_force_accumulator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise color force accumulator checker
// Watches the input, output and register ports, predicts the force sums for
// every accepted pair beat and compares each output beat against them.
// ----------------------------------------------------------------------------
module pairwise_color_force_accumulator_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  pcfa_pkg::t_in                     i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  pcfa_pkg::t_out                    i_out_data,
    input  logic                              i_cfg_we,
    input  logic [pcfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcfa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    import pcfa_pkg::*;

    localparam logic KIND_TABLE_WRITE = 1'b0;
    localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    t_cfg               shadow;
    logic signed [15:0] attraction [TAB_DEPTH];
    longint             acc_x;
    longint             acc_y;
    t_out               sums_due[$];

    assign o_pending = sums_due.size();

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos >>= 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v -= root + bitpos;
                root = (root >> 1) + bitpos;
            end else begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    function automatic longint wrap_offset(input longint d, input longint h);
        if (d > h) d -= 2 * h;
        if (d < -h) d += 2 * h;
        return d;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Product with the timestep, truncated toward zero in magnitude.
    function automatic longint apply_timestep(input longint a);
        longint unsigned mag;
        longint unsigned ts;
        longint unsigned p;
        mag = longint'(magnitude(a));
        ts = longint'(shadow.timestep);
        p = (mag >> 16) * ts + (((mag & 64'hFFFF) * ts) >> 16);
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint saturate_sum(input longint s, input longint t);
        longint r;
        r = s + t;
        if (r > SUM_HI) r = SUM_HI;
        if (r < SUM_LO) r = SUM_LO;
        return r;
    endfunction

    function automatic void pair_force(input t_in b, output longint fx, output longint fy);
        longint h, rad, ratio, dx, dy, d, rr, s, cx, cy, m, num, q;
        h = longint'(shadow.box_half_size);
        rad = longint'(shadow.interaction_radius);
        ratio = longint'(shadow.repulsion_ratio);
        dx = wrap_offset(longint'($signed(b.other_x)) - longint'($signed(b.self_x)), h);
        dy = wrap_offset(longint'($signed(b.other_y)) - longint'($signed(b.self_y)), h);
        fx = 0;
        fy = 0;
        if (magnitude(dx) > rad || magnitude(dy) > rad) return;
        d = longint'(int_sqrt(longint'(dx * dx) + longint'(dy * dy)));
        if (d == 0 || d > rad) return;
        rr = (ratio * rad) >>> 16;
        if (d <= rr) begin
            // Repulsion core: linear in distance, reaching -radius at contact.
            s = longint'((longint'(d) << 16) / longint'(ratio)) - rad;
            cx = s * dx / d;
            cy = s * dy / d;
        end else begin
            m = longint'(attraction[tab_addr(b.self_color, b.other_color)]);
            num = magnitude(2 * d - rad - rr);
            q = longint'((longint'(num) << 16) / longint'(65536 - ratio));
            s = rad - q;
            cx = (s * dx / d) * m / 4096;
            cy = (s * dy / d) * m / 4096;
        end
        fx = apply_timestep(cx);
        fy = apply_timestep(cy);
    endfunction

    always @(posedge i_clk) begin
        longint fx, fy;
        t_out want;
        int err_cnt;
        if (!i_rst_n) begin
            shadow.box_half_size <= RST_BOX_HALF;
            shadow.interaction_radius <= RST_RADIUS;
            shadow.repulsion_ratio <= RST_RATIO;
            shadow.timestep <= RST_TIMESTEP;
            acc_x <= 0;
            acc_y <= 0;
            o_errors <= 0;
        end else begin
            err_cnt = o_errors;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOX_HALF: shadow.box_half_size <= i_cfg_data;
                    CFG_RADIUS: shadow.interaction_radius <= i_cfg_data;
                    CFG_RATIO: shadow.repulsion_ratio <= i_cfg_data[15:0];
                    CFG_TIMESTEP: shadow.timestep <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.kind == KIND_TABLE_WRITE) begin
                    attraction[tab_addr(i_in_data.self_color, i_in_data.other_color)] <=
                        i_in_data.matrix_value;
                end else begin
                    fx = 0;
                    fy = 0;
                    if (!i_in_data.same_particle) pair_force(i_in_data, fx, fy);
                    fx = saturate_sum(acc_x, fx);
                    fy = saturate_sum(acc_y, fy);
                    if (i_in_data.last) begin
                        want.force_x = fx[47:0];
                        want.force_y = fy[47:0];
                        sums_due.push_back(want);
                        fx = 0;
                        fy = 0;
                    end
                    acc_x <= fx;
                    acc_y <= fy;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (sums_due.size() == 0) begin
                    $error("unexpected output beat: force_x %0d force_y %0d",
                           i_out_data.force_x, i_out_data.force_y);
                    err_cnt++;
                end else begin
                    want = sums_due.pop_front();
                    if (i_out_data.force_x !== want.force_x) begin
                        $error("force_x mismatch: expected %0d, got %0d",
                               want.force_x, i_out_data.force_x);
                        err_cnt++;
                    end
                    if (i_out_data.force_y !== want.force_y) begin
                        $error("force_y mismatch: expected %0d, got %0d",
                               want.force_y, i_out_data.force_y);
                        err_cnt++;
                    end
                end
            end
            o_errors <= err_cnt;
        end
    end

endmodule

### bench/pairwise_color_force_accumulator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise color force accumulator testbench
// Loads the attraction table, streams directed and random particle pairs
// under several register settings with random idling on both channels, and
// leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module pairwise_color_force_accumulator_test;
    import pcfa_pkg::*;

    localparam logic KIND_TABLE_WRITE = 1'b0;
    localparam logic KIND_PAIR        = 1'b1;
    localparam int   CYCLE_LIMIT      = 1000000;
    localparam int   PHASE_PAIRS      = 105;
    localparam int   IN_W             = $bits(t_in);

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_in_valid = 1'b0;
    logic         o_in_stall;
    t_in          i_in_data = '0;
    logic         o_out_valid;
    logic         i_out_stall = 1'b0;
    t_out         o_out_data;
    logic         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int           errors;
    int           pending;
    int           beats_sent = 0;
    int           cycles = 0;
    bit           quiet = 1'b0;
    bit           written [TAB_DEPTH];
    longint       cur_box = RST_BOX_HALF;
    longint       cur_rad = RST_RADIUS;
    longint       cur_ratio = RST_RATIO;

    pairwise_color_force_accumulator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    pairwise_color_force_accumulator_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pairwise_color_force_accumulator_test failed");
            $finish;
        end
    end

    // Receiver: short random stalls, plus one long hold-off so the block
    // backs up and stalls its input while pairs keep coming.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && beats_sent >= 250) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (3000) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end
        end
    end

    task automatic send_beat(input t_in b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    task automatic table_write(input int row, input int col, input logic [15:0] value,
                               input bit last);
        t_in b;
        b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        b.kind = KIND_TABLE_WRITE;
        b.self_color = row[COLOR_W-1:0];
        b.other_color = col[COLOR_W-1:0];
        b.matrix_value = value;
        b.last = last;
        written[tab_addr(b.self_color, b.other_color)] = 1'b1;
        send_beat(b);
    endtask

    // A pair never reads a table entry that has not been loaded yet.
    task automatic pair_beat(input longint sx, input longint sy, input longint ox,
                             input longint oy, input int sc, input int oc,
                             input bit same, input bit last);
        t_in b;
        if (!written[tab_addr(sc[COLOR_W-1:0], oc[COLOR_W-1:0])])
            table_write(sc, oc, 16'($urandom), 1'($urandom_range(0, 1)));
        b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        b.kind = KIND_PAIR;
        b.self_x = 32'(sx);
        b.self_y = 32'(sy);
        b.other_x = 32'(ox);
        b.other_y = 32'(oy);
        b.self_color = sc[COLOR_W-1:0];
        b.other_color = oc[COLOR_W-1:0];
        b.same_particle = same;
        b.last = last;
        send_beat(b);
    endtask

    function automatic longint random_offset(input longint lim);
        longint r;
        if (lim <= 0) return 0;
        if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
        r = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF);
        return (r % (2 * lim + 1)) - lim;
    endfunction

    task automatic random_pair(input bit last);
        longint sx, sy, ox, oy, lim;
        int mode;
        sx = longint'($signed($urandom));
        sy = longint'($signed($urandom));
        mode = $urandom_range(0, 9);
        lim = (mode == 6) ? ((cur_rad * cur_ratio) >>> 17) : (cur_rad + cur_rad / 4);
        ox = sx + random_offset(lim);
        oy = sy + random_offset(lim);
        if (mode == 7) begin
            ox = sx;
            oy = sy;
        end else if (mode == 8) begin
            ox = longint'($signed($urandom));
            oy = longint'($signed($urandom));
        end else if (mode == 9) begin
            // Neighbour seen across the periodic boundary.
            ox = ox + 2 * cur_box;
            oy = oy - 2 * cur_box;
        end
        pair_beat(sx, sy, ox, oy, $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 9) == 0, last);
    endtask

    task automatic set_regs(input longint box, input longint rad, input longint ratio,
                            input longint ts);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        // The final pair of a phase always emits, so this only covers drain slack.
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_BOX_HALF;
        i_cfg_data <= 31'(box);
        @(negedge i_clk);
        i_cfg_idx <= CFG_RADIUS;
        i_cfg_data <= 31'(rad);
        @(negedge i_clk);
        i_cfg_idx <= CFG_RATIO;
        i_cfg_data <= 31'(ratio);
        @(negedge i_clk);
        i_cfg_idx <= CFG_TIMESTEP;
        i_cfg_data <= 31'(ts);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_box = box;
        cur_rad = rad;
        cur_ratio = ratio;
    endtask

    task automatic random_phase();
        int n, len;
        n = 0;
        while (n < PHASE_PAIRS) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    table_write($urandom_range(0, 7), $urandom_range(0, 7),
                                16'($urandom), 1'($urandom_range(0, 1)));
                random_pair(k == len - 1);
                n++;
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset settings (radius 10, core 3).
        table_write(0, 0, 16'sh7FFF, 1'b0);
        table_write(7, 7, 16'sh8000, 1'b0);
        table_write(0, 7, 16'sh0001, 1'b0);
        table_write(7, 0, 16'sh1000, 1'b0);
        pair_beat(0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
        pair_beat(0, 0, 65536, 0, 0, 0, 1'b1, 1'b1);
        pair_beat(0, 0, 65536, 0, 0, 0, 1'b0, 1'b0);
        pair_beat(0, 0, 0, 5 * 65536, 7, 7, 1'b0, 1'b0);
        pair_beat(0, 0, 0, 20 * 65536, 0, 0, 1'b0, 1'b1);
        pair_beat(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
                  -64'sd2147483648, 7, 0, 1'b0, 1'b1);
        pair_beat(0, 0, 655360, 0, 0, 7, 1'b0, 1'b0);
        pair_beat(0, 0, 655361, 0, 0, 7, 1'b0, 1'b1);
        pair_beat(0, 0, 6553600, 6553600, 7, 7, 1'b0, 1'b1);
        table_write(3, 5, 16'shF000, 1'b1);
        pair_beat(100, 100, 100 + 400000, 100 - 300000, 3, 5, 1'b0, 1'b1);
        random_phase();

        set_regs(64'h7FFF_FFFF, 64'h7FFF_FFFF, 65535, 64'h7FFF_FFFF);
        random_phase();
        set_regs(1, 1, 1, 1);
        random_phase();
        set_regs(100 * 65536, 20 * 65536, 32768, 65536);
        random_phase();
        quiet = 1'b1;
        set_regs($urandom_range(1, 32'h7FFF_FFFF), $urandom_range(65536, 50 * 65536),
                 $urandom_range(1, 65535), $urandom_range(1, 1 << 20));
        random_phase();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("pairwise_color_force_accumulator_test passed");
        end else begin
            $display("pairwise_color_force_accumulator_test failed");
        end
        $finish;
    end

endmodule
